// ----- rtl/ort_pkg.sv -----
`timescale 1ns / 1ps

package ort_pkg;

    localparam int NUM_PORTS_DEF = 5;
    localparam int OP_W          = 3;
    localparam int PORT_W        = 3;
    localparam int PIN_N         = 2 ** PORT_W;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR      = 3'd0,
        OP_RESERVE    = 3'd1,
        OP_RELEASE    = 3'd2,
        OP_INVALIDATE = 3'd3,
        OP_QUERY      = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_FREE    = 2'd0,
        ST_OWNED   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [PORT_W-1:0] port_in;
        logic [PORT_W-1:0] dest_port;
    } t_in_word;

    typedef struct packed {
        logic              out_port_free;
        logic              input_holds_output;
        logic [PORT_W-1:0] held_output;
        logic              error;
    } t_out_word;

endpackage

// ----- rtl/ort_table.sv -----
`timescale 1ns / 1ps

module ort_table #(
    parameter int NUM_PORTS = ort_pkg::NUM_PORTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_upd,
    input  ort_pkg::t_in_word i_word,
    output ort_pkg::t_out_word o_res
);

    ort_pkg::t_status              r_status [NUM_PORTS];
    logic [ort_pkg::PORT_W-1:0]    r_owner  [NUM_PORTS];
    ort_pkg::t_status              n_status [NUM_PORTS];
    logic [ort_pkg::PORT_W-1:0]    n_owner  [NUM_PORTS];

    logic                          in_ok;
    logic                          out_ok;
    logic                          err;
    logic [NUM_PORTS-1:0]          sel;
    logic [NUM_PORTS-1:0]          cur_free;
    logic [NUM_PORTS-1:0]          cur_owned;
    logic [NUM_PORTS-1:0]          own_pre;
    logic [NUM_PORTS-1:0]          held_pre;
    logic [NUM_PORTS-1:0]          own_post;
    logic [NUM_PORTS-1:0]          held_post;
    logic [NUM_PORTS-1:0]          post_free;
    logic [ort_pkg::PORT_W-1:0]    held_idx;
    logic [NUM_PORTS-1:0]          own_map [ort_pkg::PIN_N];

    always_comb begin
        in_ok  = int'(i_word.port_in) < NUM_PORTS;
        out_ok = int'(i_word.dest_port) < NUM_PORTS;
        for (int i = 0; i < NUM_PORTS; i++) begin
            sel[i]       = int'(i_word.dest_port) == i;
            cur_free[i]  = r_status[i] == ort_pkg::ST_FREE;
            cur_owned[i] = r_status[i] == ort_pkg::ST_OWNED;
            own_pre[i]   = cur_owned[i] && (r_owner[i] == i_word.port_in);
        end
        // lowest set bit
        held_pre = own_pre & ~(own_pre - NUM_PORTS'(1));
    end

    always_comb begin
        err = 1'b0;
        for (int i = 0; i < NUM_PORTS; i++) begin
            n_status[i] = r_status[i];
            n_owner[i]  = r_owner[i];
        end
        unique case (i_word.operation)
            ort_pkg::OP_CLEAR: begin
                for (int i = 0; i < NUM_PORTS; i++) begin
                    if (r_status[i] != ort_pkg::ST_INVALID) begin
                        n_status[i] = ort_pkg::ST_FREE;
                        n_owner[i]  = '0;
                    end
                end
            end
            ort_pkg::OP_RESERVE: begin
                if (!in_ok || !out_ok || !(|(sel & cur_free))) begin
                    err = 1'b1;
                end else begin
                    for (int i = 0; i < NUM_PORTS; i++) begin
                        if (held_pre[i]) begin
                            n_status[i] = ort_pkg::ST_FREE;
                            n_owner[i]  = '0;
                        end
                        if (sel[i]) begin
                            n_status[i] = ort_pkg::ST_OWNED;
                            n_owner[i]  = i_word.port_in;
                        end
                    end
                end
            end
            ort_pkg::OP_RELEASE: begin
                if (!out_ok || !(|(sel & cur_owned))) begin
                    err = 1'b1;
                end else begin
                    for (int i = 0; i < NUM_PORTS; i++) begin
                        if (sel[i]) begin
                            n_status[i] = ort_pkg::ST_FREE;
                            n_owner[i]  = '0;
                        end
                    end
                end
            end
            ort_pkg::OP_INVALIDATE: begin
                if (!out_ok) begin
                    err = 1'b1;
                end else begin
                    for (int i = 0; i < NUM_PORTS; i++) begin
                        if (sel[i]) begin
                            n_status[i] = ort_pkg::ST_INVALID;
                            n_owner[i]  = '0;
                        end
                    end
                end
            end
            ort_pkg::OP_QUERY: begin
                err = !in_ok || !out_ok;
            end
            default: begin
                err = 1'b1;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < NUM_PORTS; i++) begin
            own_post[i]  = (n_status[i] == ort_pkg::ST_OWNED) &&
                           (n_owner[i] == i_word.port_in);
            post_free[i] = n_status[i] == ort_pkg::ST_FREE;
        end
        held_post = own_post & ~(own_post - NUM_PORTS'(1));
        held_idx  = '0;
        for (int i = 0; i < NUM_PORTS; i++) begin
            if (held_post[i]) begin
                held_idx = held_idx | ort_pkg::PORT_W'(i);
            end
        end
        o_res.out_port_free      = out_ok && (|(sel & post_free));
        o_res.input_holds_output = in_ok && (|own_post);
        o_res.held_output        = in_ok ? held_idx : '0;
        o_res.error              = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_status[i] <= ort_pkg::ST_FREE;
                r_owner[i]  <= '0;
            end
        end else if (i_upd) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                r_status[i] <= n_status[i];
                r_owner[i]  <= n_owner[i];
            end
        end
    end

    // ownership map per input port
    always_comb begin
        for (int p = 0; p < ort_pkg::PIN_N; p++) begin
            for (int i = 0; i < NUM_PORTS; i++) begin
                own_map[p][i] = (r_status[i] == ort_pkg::ST_OWNED) &&
                                (int'(r_owner[i]) == p);
            end
        end
    end

    generate
        for (genvar p = 0; p < ort_pkg::PIN_N; p++) begin : g_one_owner
            a_one_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                $countones(own_map[p]) <= 1)
                else $error("input owns more than one output");
        end
        for (genvar i = 0; i < NUM_PORTS; i++) begin : g_entry
            a_invalid_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                r_status[i] == ort_pkg::ST_INVALID |=> r_status[i] == ort_pkg::ST_INVALID)
                else $error("invalid entry came back into use");
            a_owner_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                r_status[i] != ort_pkg::ST_OWNED |-> r_owner[i] == '0)
                else $error("unowned entry keeps an owner");
            a_err_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                i_upd && err |=> $stable(r_status[i]) && $stable(r_owner[i]))
                else $error("table changed on an illegal operation");
        end
    endgenerate

endmodule

// ----- rtl/router_output_reservation_table.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake                   word
// in        to block   i_in_valid / o_in_stall     i_in_word  (t_in_word)
// out       from block o_out_valid / i_out_stall   o_out_word (t_out_word)
//
// one word per cycle sustained while the output is not stalled
// path: input register, table update and lookup, result register
// the table is written as a word moves into the result register
// reset frees every entry at once and empties both registers
// a stall on the result side holds the input register and then stalls the input

module router_output_reservation_table #(
    parameter int NUM_PORTS = ort_pkg::NUM_PORTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ort_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ort_pkg::t_out_word o_out_word
);

    logic               r_in_valid;
    ort_pkg::t_in_word  r_in_word;
    logic               r_out_valid;
    ort_pkg::t_out_word r_out_word;
    ort_pkg::t_out_word res;
    logic               out_load;
    logic               advance;

    assign out_load   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_load;
    assign o_in_stall = r_in_valid && !out_load;

    ort_table #(
        .NUM_PORTS (NUM_PORTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (advance),
        .i_word  (r_in_word),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_word <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int N_PORTS     = ort_pkg::NUM_PORTS_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 200000;
    localparam int N_DIRECTED  = 26;

    localparam logic [ort_pkg::OP_W-1:0] OP_UNUSED5 = 3'd5;
    localparam logic [ort_pkg::OP_W-1:0] OP_UNUSED6 = 3'd6;
    localparam logic [ort_pkg::OP_W-1:0] OP_UNUSED7 = 3'd7;

    typedef struct {
        logic [ort_pkg::OP_W-1:0]   op;
        logic [ort_pkg::PORT_W-1:0] pin;
        logic [ort_pkg::PORT_W-1:0] pout;
        bit                         fixed;
        ort_pkg::t_out_word         want;
    } t_row;

    typedef struct {
        bit                 fixed;
        ort_pkg::t_out_word want;
    } t_tag;

    typedef struct {
        ort_pkg::t_out_word pred;
        bit                 fixed;
        ort_pkg::t_out_word want;
    } t_expect;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    ort_pkg::t_in_word  i_in_word   = '0;
    logic               i_out_stall = 1'b0;
    logic               o_in_stall;
    logic               o_out_valid;
    ort_pkg::t_out_word o_out_word;

    ort_pkg::t_status           port_state [N_PORTS];
    logic [ort_pkg::PORT_W-1:0] port_owner [N_PORTS];

    t_tag    tag_q [$];
    t_expect result_q [$];
    t_row    dir_rows [N_DIRECTED];

    int  mismatches   = 0;
    int  words_sent   = 0;
    int  results_seen = 0;
    int  n_reserved   = 0;
    int  n_rejected   = 0;
    int  cycle_cnt    = 0;
    bit  hold_req     = 1'b0;
    bit  quiet        = 1'b0;

    router_output_reservation_table dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    always #10 i_clk = ~i_clk;

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
        mismatches++;
    endtask

    task automatic check_word(ort_pkg::t_out_word got, ort_pkg::t_out_word want,
                              string src);
        if (got.out_port_free !== want.out_port_free)
            report({src, " out_port_free"}, int'(got.out_port_free),
                   int'(want.out_port_free));
        if (got.input_holds_output !== want.input_holds_output)
            report({src, " input_holds_output"}, int'(got.input_holds_output),
                   int'(want.input_holds_output));
        if (got.held_output !== want.held_output)
            report({src, " held_output"}, int'(got.held_output), int'(want.held_output));
        if (got.error !== want.error)
            report({src, " error"}, int'(got.error), int'(want.error));
    endtask

    function automatic bit lowest_held(logic [ort_pkg::PORT_W-1:0] pin,
                                       output logic [ort_pkg::PORT_W-1:0] idx);
        idx = '0;
        for (int i = 0; i < N_PORTS; i++) begin
            if (port_state[i] == ort_pkg::ST_OWNED && port_owner[i] == pin) begin
                idx = ort_pkg::PORT_W'(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic ort_pkg::t_out_word apply_to_table(ort_pkg::t_in_word w);
        ort_pkg::t_out_word         res;
        logic [ort_pkg::PORT_W-1:0] held;
        bit                         in_ok;
        bit                         out_ok;
        bit                         err;
        bit                         holds;
        in_ok  = w.port_in < N_PORTS;
        out_ok = w.dest_port < N_PORTS;
        err    = 1'b0;
        unique case (w.operation)
            ort_pkg::OP_CLEAR: begin
                for (int i = 0; i < N_PORTS; i++) begin
                    if (port_state[i] != ort_pkg::ST_INVALID) begin
                        port_state[i] = ort_pkg::ST_FREE;
                        port_owner[i] = '0;
                    end
                end
            end
            ort_pkg::OP_RESERVE: begin
                if (!in_ok || !out_ok) begin
                    err = 1'b1;
                end else if (port_state[w.dest_port] != ort_pkg::ST_FREE) begin
                    err = 1'b1;
                end else begin
                    if (lowest_held(w.port_in, held)) begin
                        port_state[held] = ort_pkg::ST_FREE;
                        port_owner[held] = '0;
                    end
                    port_state[w.dest_port] = ort_pkg::ST_OWNED;
                    port_owner[w.dest_port] = w.port_in;
                    n_reserved++;
                end
            end
            ort_pkg::OP_RELEASE: begin
                if (!out_ok) begin
                    err = 1'b1;
                end else if (port_state[w.dest_port] != ort_pkg::ST_OWNED) begin
                    err = 1'b1;
                end else begin
                    port_state[w.dest_port] = ort_pkg::ST_FREE;
                    port_owner[w.dest_port] = '0;
                end
            end
            ort_pkg::OP_INVALIDATE: begin
                if (!out_ok) begin
                    err = 1'b1;
                end else begin
                    port_state[w.dest_port] = ort_pkg::ST_INVALID;
                    port_owner[w.dest_port] = '0;
                end
            end
            ort_pkg::OP_QUERY: begin
                if (!in_ok || !out_ok)
                    err = 1'b1;
            end
            default: err = 1'b1;
        endcase
        holds = 1'b0;
        held  = '0;
        if (in_ok)
            holds = lowest_held(w.port_in, held);
        res.out_port_free      = out_ok ? (port_state[w.dest_port] == ort_pkg::ST_FREE) : 1'b0;
        res.input_holds_output = holds;
        res.held_output        = held;
        res.error              = err;
        if (err)
            n_rejected++;
        return res;
    endfunction

    function automatic logic [ort_pkg::PORT_W-1:0] random_port();
        if ($urandom_range(0, 15) == 0)
            return ort_pkg::PORT_W'($urandom_range(N_PORTS, 7));
        return ort_pkg::PORT_W'($urandom_range(0, N_PORTS - 1));
    endfunction

    function automatic ort_pkg::t_in_word random_request(bit allow_invalidate);
        ort_pkg::t_in_word w;
        int                r;
        r = $urandom_range(0, 63);
        if (r < 24)
            w.operation = ort_pkg::OP_RESERVE;
        else if (r < 38)
            w.operation = ort_pkg::OP_RELEASE;
        else if (r < 52)
            w.operation = ort_pkg::OP_QUERY;
        else if (r < 56)
            w.operation = ort_pkg::OP_CLEAR;
        else if (r < 59)
            w.operation = ort_pkg::OP_W'($urandom_range(OP_UNUSED5, OP_UNUSED7));
        else if (r < 63)
            w.operation = ort_pkg::OP_QUERY;
        else
            w.operation = allow_invalidate ? ort_pkg::OP_INVALIDATE : ort_pkg::OP_RESERVE;
        w.port_in   = random_port();
        w.dest_port = random_port();
        return w;
    endfunction

    task automatic send_word(ort_pkg::t_in_word w, bit fixed, ort_pkg::t_out_word want);
        tag_q.push_back('{fixed, want});
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        words_sent++;
    endtask

    task automatic idle_gap();
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 18);
            i_in_valid <= 1'b0;
            i_in_word  <= ort_pkg::t_in_word'($urandom);
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (results_seen != words_sent)
            @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : accept_mon
        t_tag    tg;
        t_expect ex;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            if (tag_q.size() == 0) begin
                tg = '{1'b0, '0};
            end else begin
                tg = tag_q.pop_front();
            end
            ex.pred  = apply_to_table(i_in_word);
            ex.fixed = tg.fixed;
            ex.want  = tg.want;
            result_q.push_back(ex);
        end
    end

    always @(posedge i_clk) begin : result_mon
        t_expect ex;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_q.size() == 0) begin
                report("unexpected result word", int'(o_out_word), 0);
            end else begin
                ex = result_q.pop_front();
                check_word(o_out_word, ex.pred, "predicted");
                if (ex.fixed)
                    check_word(o_out_word, ex.want, "directed");
            end
            results_seen++;
        end
    end

    initial begin : receiver
        int n;
        int hold_cnt;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(posedge i_clk);
                hold_req = 1'b0;
            end else if (quiet) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 18);
                i_out_stall <= ($urandom_range(0, 2) == 0);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : sender
        ort_pkg::t_in_word w;
        for (int i = 0; i < N_PORTS; i++) begin
            port_state[i] = ort_pkg::ST_FREE;
            port_owner[i] = '0;
        end
        dir_rows = '{
            '{ort_pkg::OP_QUERY,      3'd0, 3'd0, 1'b1, '{1'b1, 1'b0, 3'd0, 1'b0}},
            '{ort_pkg::OP_QUERY,      3'd7, 3'd7, 1'b1, '{1'b0, 1'b0, 3'd0, 1'b1}},
            '{ort_pkg::OP_RESERVE,    3'd0, 3'd4, 1'b1, '{1'b0, 1'b1, 3'd4, 1'b0}},
            '{ort_pkg::OP_RESERVE,    3'd1, 3'd4, 1'b1, '{1'b0, 1'b0, 3'd0, 1'b1}},
            '{ort_pkg::OP_RESERVE,    3'd0, 3'd0, 1'b0, '0},
            '{ort_pkg::OP_RESERVE,    3'd0, 3'd0, 1'b1, '{1'b0, 1'b1, 3'd0, 1'b1}},
            '{ort_pkg::OP_RELEASE,    3'd3, 3'd2, 1'b1, '{1'b1, 1'b0, 3'd0, 1'b1}},
            '{ort_pkg::OP_RESERVE,    3'd3, 3'd4, 1'b0, '0},
            '{ort_pkg::OP_INVALIDATE, 3'd0, 3'd4, 1'b0, '0},
            '{ort_pkg::OP_RESERVE,    3'd2, 3'd4, 1'b1, '{1'b0, 1'b0, 3'd0, 1'b1}},
            '{ort_pkg::OP_RELEASE,    3'd6, 3'd4, 1'b1, '{1'b0, 1'b0, 3'd0, 1'b1}},
            '{ort_pkg::OP_RESERVE,    3'd5, 3'd1, 1'b1, '{1'b1, 1'b0, 3'd0, 1'b1}},
            '{ort_pkg::OP_RESERVE,    3'd1, 3'd5, 1'b1, '{1'b0, 1'b0, 3'd0, 1'b1}},
            '{ort_pkg::OP_RELEASE,    3'd7, 3'd0, 1'b0, '0},
            '{ort_pkg::OP_INVALIDATE, 3'd1, 3'd7, 1'b1, '{1'b0, 1'b0, 3'd0, 1'b1}},
            '{ort_pkg::OP_QUERY,      3'd5, 3'd3, 1'b1, '{1'b1, 1'b0, 3'd0, 1'b1}},
            '{OP_UNUSED5,             3'd0, 3'd1, 1'b0, '0},
            '{OP_UNUSED6,             3'd6, 3'd6, 1'b0, '0},
            '{OP_UNUSED7,             3'd4, 3'd3, 1'b0, '0},
            '{ort_pkg::OP_RESERVE,    3'd3, 3'd1, 1'b0, '0},
            '{ort_pkg::OP_RESERVE,    3'd2, 3'd3, 1'b0, '0},
            '{ort_pkg::OP_RESERVE,    3'd4, 3'd2, 1'b0, '0},
            '{ort_pkg::OP_CLEAR,      3'd2, 3'd4, 1'b0, '0},
            '{ort_pkg::OP_CLEAR,      3'd7, 3'd7, 1'b1, '{1'b0, 1'b0, 3'd0, 1'b0}},
            '{ort_pkg::OP_RESERVE,    3'd1, 3'd3, 1'b0, '0},
            '{ort_pkg::OP_QUERY,      3'd1, 3'd3, 1'b0, '0}
        };
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            w.operation = dir_rows[i].op;
            w.port_in   = dir_rows[i].pin;
            w.dest_port = dir_rows[i].pout;
            send_word(w, dir_rows[i].fixed, dir_rows[i].want);
            idle_gap();
        end

        for (int i = 0; i < 300; i++) begin
            send_word(random_request(1'b0), 1'b0, '0);
            idle_gap();
        end

        // receiver holds off while words keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_word(random_request(1'b0), 1'b0, '0);
        drain();

        for (int i = 0; i < 260; i++) begin
            send_word(random_request(1'b1), 1'b0, '0);
            idle_gap();
        end

        quiet = 1'b1;
        for (int i = 0; i < 100; i++)
            send_word(random_request(1'b1), 1'b0, '0);
        drain();
        repeat (8) @(posedge i_clk);

        if (result_q.size() != 0)
            report("results never delivered", result_q.size(), 0);
        $display("covered %0d words (%0d directed), %0d checked results", words_sent,
                 N_DIRECTED, results_seen);
        $display("legal reserves %0d, rejected operations %0d, one long result-side hold",
                 n_reserved, n_rejected);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
